// ===== hdl/pbtb_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pbtb_pkg: shared types and constants of the proportional text blitter
// Item structs, command and register codes, store geometry.
// ============================================================================
package pbtb_pkg;

    localparam int MAX_GLYPH_WIDTH  = 16;
    localparam int MAX_GLYPH_HEIGHT = 32;
    localparam int GLYPH_COUNT      = 256;
    localparam int ADDRESS_BITS     = 24;

    localparam int CODE_W  = $clog2(GLYPH_COUNT);
    localparam int ROW_W   = $clog2(MAX_GLYPH_HEIGHT);
    localparam int ROWS_W  = $clog2(MAX_GLYPH_HEIGHT + 1);
    localparam int STORE_W = CODE_W + ROW_W;

    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DIGIT_LO   = 8'h30;
    localparam logic [7:0] CH_DIGIT_HI   = 8'h39;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_MEASURE = 2'd1,
        CMD_DRAW    = 2'd2,
        CMD_NONE    = 2'd3
    } t_command;

    typedef enum logic [2:0] {
        CFG_SCREEN_STRIDE = 3'd0,
        CFG_GLYPH_WIDTH   = 3'd1,
        CFG_GLYPH_HEIGHT  = 3'd2,
        CFG_CHAR_SPACING  = 3'd3,
        CFG_ALIGN_RIGHT   = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  char_code;
        logic [4:0]  glyph_row;
        logic [15:0] row_bits;
        logic        first_of_string;
        logic [15:0] pos_x;
        logic [11:0] pos_y;
        logic [7:0]  color;
    } t_in_item;

    typedef struct packed {
        logic [23:0] write_address;
        logic [15:0] write_mask;
        logic [7:0]  write_color;
        logic        last_row;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic             accept;
        logic             mc_read;
        logic             store_write;
        logic             load_update;
        logic             measure_update;
        logic             pen_set;
        logic             base_calc;
        logic             row_issue;
        logic             row_last;
        logic [ROW_W-1:0] row_index;
        logic             advance;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_command          op;
        logic [ROWS_W-1:0] rows;
        logic              rd_ok;
    } t_status;

endpackage

// ===== hdl/pbtb_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pbtb_ctrl: item sequencer
// Walks each item through read and update steps, or for draws base, row-issue and advance steps.
// ============================================================================
module pbtb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  pbtb_pkg::t_status i_status,
    output pbtb_pkg::t_cmd  o_cmd
);
    import pbtb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LOAD_UPD,
        S_MEAS_UPD,
        S_BASE,
        S_ROW,
        S_ADV
    } t_state;

    t_state            r_state, n_state;
    logic [ROWS_W-1:0] r_row, n_row;
    logic              w_last;

    assign w_last     = (r_row == (i_status.rows - ROWS_W'(1)));
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                case (i_status.op)
                    CMD_LOAD:    n_state = S_LOAD_UPD;
                    CMD_MEASURE: n_state = S_MEAS_UPD;
                    CMD_DRAW:    n_state = S_BASE;
                    default:     n_state = S_IDLE;
                endcase
            end
            S_LOAD_UPD: n_state = S_IDLE;
            S_MEAS_UPD: n_state = S_IDLE;
            S_BASE: begin
                n_row   = '0;
                n_state = (i_status.rows == '0) ? S_ADV : S_ROW;
            end
            S_ROW: begin
                if (i_status.rd_ok) begin
                    n_row = r_row + ROWS_W'(1);
                    if (w_last) begin
                        n_state = S_ADV;
                    end
                end
            end
            S_ADV:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd                = '0;
        o_cmd.accept         = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mc_read        = (r_state == S_READ);
        o_cmd.store_write    = (r_state == S_READ) && (i_status.op == CMD_LOAD);
        o_cmd.pen_set        = (r_state == S_READ) && (i_status.op == CMD_DRAW);
        o_cmd.load_update    = (r_state == S_LOAD_UPD);
        o_cmd.measure_update = (r_state == S_MEAS_UPD);
        o_cmd.base_calc      = (r_state == S_BASE);
        o_cmd.row_issue      = (r_state == S_ROW) && i_status.rd_ok;
        o_cmd.row_last       = w_last;
        o_cmd.row_index      = r_row[ROW_W-1:0];
        o_cmd.advance        = (r_state == S_ADV);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
        end
    end

endmodule

// ===== hdl/pbtb_datapath.sv =====
`timescale 1ns / 1ps
// ============================================================================
// pbtb_datapath: glyph stores, pen, totals and result register
// Holds configuration, both glyph memories and the row write output stage.
// ============================================================================
module pbtb_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_write_enable,
    input  logic [2:0]          i_cfg_index,
    input  logic [12:0]         i_cfg_data,
    input  pbtb_pkg::t_in_item  i_in,
    input  pbtb_pkg::t_cmd      i_cmd,
    output pbtb_pkg::t_status   o_status,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pbtb_pkg::t_out_item o_out
);
    import pbtb_pkg::*;

    localparam int AW = ADDRESS_BITS;

    // configuration
    logic [12:0] r_stride;
    logic [4:0]  r_gwidth;
    logic [5:0]  r_gheight;
    logic [7:0]  r_spacing;
    logic        r_align;

    // item and state
    t_in_item    r_item;
    logic [3:0]  r_digit_max;
    logic [15:0] r_total;
    logic [15:0] r_pen_col;
    logic [11:0] r_pen_row;
    logic [AW-1:0] r_row_acc;

    // memories
    logic [MAX_GLYPH_WIDTH-1:0] r_store [GLYPH_COUNT*MAX_GLYPH_HEIGHT];
    logic [MAX_GLYPH_WIDTH-1:0] r_store_rd;
    logic [3:0]                 r_mc_mem [GLYPH_COUNT];
    logic [GLYPH_COUNT-1:0]     r_mc_valid;
    logic [3:0]                 r_mc_rd;
    logic                       r_mc_rd_vld;

    // pending row and output
    logic          r_pend;
    logic [AW-1:0] r_pend_addr;
    logic          r_pend_last;
    logic [7:0]    r_pend_color;
    logic          r_out_valid;
    t_out_item     r_out;

    logic [CODE_W-1:0]          w_code;
    logic [CODE_W-1:0]          w_mc_addr;
    logic [4:0]                 w_width;
    logic [16:0]                w_mask_wide;
    logic [MAX_GLYPH_WIDTH-1:0] w_cmask;
    logic [MAX_GLYPH_WIDTH-1:0] w_lit;
    logic [3:0]                 w_col;
    logic [3:0]                 w_mc;
    logic [3:0]                 w_new_mc;
    logic                       w_is_digit;
    logic [4:0]                 w_adv;
    logic [15:0]                w_total_base;
    logic [16:0]                w_sum;
    logic [15:0]                w_right_col;
    logic                       w_out_free;
    logic                       w_load_now;
    logic [STORE_W-1:0]         w_wr_addr;
    logic [STORE_W-1:0]         w_rd_addr;

    assign w_code    = r_item.char_code[CODE_W-1:0];
    assign w_mc_addr = (r_item.char_code == CH_SPACE) ? CH_UNDERSCORE[CODE_W-1:0] : w_code;
    assign w_wr_addr = {w_code, r_item.glyph_row[ROW_W-1:0]};
    assign w_rd_addr = {w_code, i_cmd.row_index};

    // column mask limited to the cell width
    assign w_width     = (r_gwidth > 5'(MAX_GLYPH_WIDTH)) ? 5'(MAX_GLYPH_WIDTH) : r_gwidth;
    assign w_mask_wide = (17'd1 << w_width) - 17'd1;
    assign w_cmask     = w_mask_wide[MAX_GLYPH_WIDTH-1:0];
    assign w_lit       = r_item.row_bits & w_cmask;

    // rightmost lit column
    always_comb begin
        w_col = '0;
        for (int c = 0; c < MAX_GLYPH_WIDTH; c++) begin
            if (w_lit[c]) begin
                w_col = 4'(c);
            end
        end
    end

    assign w_mc       = r_mc_rd_vld ? r_mc_rd : 4'd0;
    assign w_new_mc   = (w_col > w_mc) ? w_col : w_mc;
    assign w_is_digit = (r_item.char_code >= CH_DIGIT_LO) && (r_item.char_code <= CH_DIGIT_HI);

    // advance width: space borrows underscore width minus one, digits share one width
    always_comb begin
        if (r_item.char_code == CH_SPACE) begin
            w_adv = {1'b0, w_mc};
        end else if (w_is_digit) begin
            w_adv = {1'b0, r_digit_max} + 5'd1;
        end else begin
            w_adv = {1'b0, w_mc} + 5'd1;
        end
    end

    assign w_total_base = r_item.first_of_string ? 16'd0 : r_total;
    assign w_sum        = {1'b0, w_total_base} + 17'(w_adv) + 17'(r_spacing);
    assign w_right_col  = (r_item.pos_x > r_total) ? (r_item.pos_x - r_total) : 16'd0;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_load_now = r_pend && w_out_free;

    always_comb begin
        o_status.op    = t_command'(r_item.command);
        o_status.rows  = (r_gheight > 6'(MAX_GLYPH_HEIGHT)) ?
                         ROWS_W'(MAX_GLYPH_HEIGHT) : ROWS_W'(r_gheight);
        o_status.rd_ok = !r_pend || w_load_now;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride  <= 13'd640;
            r_gwidth  <= 5'd8;
            r_gheight <= 6'd8;
            r_spacing <= 8'd0;
            r_align   <= 1'b0;
        end else if (i_cfg_write_enable) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_SCREEN_STRIDE: r_stride  <= i_cfg_data;
                CFG_GLYPH_WIDTH:   r_gwidth  <= i_cfg_data[4:0];
                CFG_GLYPH_HEIGHT:  r_gheight <= i_cfg_data[5:0];
                CFG_CHAR_SPACING:  r_spacing <= i_cfg_data[7:0];
                CFG_ALIGN_RIGHT:   r_align   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // capture item, row address base
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_in;
        end
        if (i_cmd.base_calc) begin
            r_row_acc <= AW'(r_stride * r_pen_row);
        end else if (i_cmd.row_issue) begin
            r_row_acc <= r_row_acc + AW'(r_stride);
        end
    end

    // glyph row store
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_write) begin
            r_store[w_wr_addr] <= r_item.row_bits;
        end
        if (i_cmd.row_issue) begin
            r_store_rd <= r_store[w_rd_addr];
        end
    end

    // rightmost column store
    always_ff @(posedge i_clk) begin
        if (i_cmd.mc_read) begin
            r_mc_rd <= r_mc_mem[w_mc_addr];
        end
        if (i_cmd.load_update) begin
            r_mc_mem[w_code] <= w_new_mc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mc_valid  <= '0;
            r_mc_rd_vld <= 1'b0;
            r_digit_max <= '0;
            r_total     <= '0;
            r_pen_col   <= '0;
            r_pen_row   <= '0;
        end else begin
            if (i_cmd.mc_read) begin
                r_mc_rd_vld <= r_mc_valid[w_mc_addr];
            end
            if (i_cmd.load_update) begin
                r_mc_valid[w_code] <= 1'b1;
                if (w_is_digit && (w_col > r_digit_max)) begin
                    r_digit_max <= w_col;
                end
            end
            if (i_cmd.measure_update) begin
                r_total <= w_sum[16] ? 16'hFFFF : w_sum[15:0];
            end
            if (i_cmd.pen_set && r_item.first_of_string) begin
                r_pen_row <= r_item.pos_y;
                r_pen_col <= r_align ? w_right_col : r_item.pos_x;
            end
            if (i_cmd.advance) begin
                r_pen_col <= r_pen_col + 16'(w_adv) + 16'(r_spacing);
            end
        end
    end

    // pending row: address and tag held until the output register is free
    always_ff @(posedge i_clk) begin
        if (i_cmd.row_issue) begin
            r_pend_addr  <= r_row_acc + AW'(r_pen_col);
            r_pend_last  <= i_cmd.row_last;
            r_pend_color <= r_item.color;
        end
        if (w_load_now) begin
            r_out.write_address <= 24'(r_pend_addr);
            r_out.write_mask    <= r_store_rd & w_cmask;
            r_out.write_color   <= r_pend_color;
            r_out.last_row      <= r_pend_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.row_issue) begin
                r_pend <= 1'b1;
            end else if (w_load_now) begin
                r_pend <= 1'b0;
            end
            if (w_load_now) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== hdl/proportional_bitmap_text_blitter.sv =====
`timescale 1ns / 1ps
// Load and measure transactions step through store read and update before the next accept.
// Draw: read and base setup steps, then one row write per cycle while the output does not
// stall (glyph store read port), then a pen-advance step.
// The first row write is presented through the pending-row stage and the registered output.
// Reset (synchronous, active low) clears pen, totals, widths and all column valid bits;
// the glyph row store is left as is and must be loaded before use.
// ============================================================================
// proportional_bitmap_text_blitter: top level
// Glyph loader, string measure and masked row blitter with proportional advance.
// ============================================================================
module proportional_bitmap_text_blitter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration write port
    input  logic                i_cfg_write_enable,
    input  logic [2:0]          i_cfg_index,
    input  logic [12:0]         i_cfg_data,
    // input transactions
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pbtb_pkg::t_in_item  i_in,
    // row write transactions
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pbtb_pkg::t_out_item o_out
);
    import pbtb_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // Sequencer: accepts a transaction only when idle, then steps it through
    // store read and then an update or, for draws, one row issue per free output slot.
    pbtb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Datapath: glyph memories, pen and totals, plus a pending-row stage in
    // front of the output register so rows keep flowing while one waits.
    pbtb_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_write_enable (i_cfg_write_enable),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in               (i_in),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_out              (o_out)
    );

endmodule

// ===== bench/proportional_bitmap_text_blitter_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// proportional_bitmap_text_blitter_tb: self-checking bench of the text blitter
// Feeds glyph loads, string measures and draws through the input channel,
// predicts every framebuffer row write and checks them in order as they leave.
// ============================================================================
module proportional_bitmap_text_blitter_tb;
    import pbtb_pkg::*;

    localparam int PERIOD_NS     = 8;
    localparam int SETTLE_CYCLES = 48;     // longest draw is 32 rows plus setup
    localparam int MAX_PRINTED   = 100;
    localparam int LIMIT_CYCLES  = 500000;

    logic        i_clk              = 1'b0;
    logic        i_rst_n            = 1'b0;
    logic        i_cfg_write_enable = 1'b0;
    t_cfg_index  i_cfg_index        = CFG_SCREEN_STRIDE;
    logic [12:0] i_cfg_data         = '0;
    logic        i_in_valid         = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in               = '0;
    logic        o_out_valid;
    logic        i_out_stall        = 1'b0;
    t_out_item   o_out;

    proportional_bitmap_text_blitter uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_write_enable(i_cfg_write_enable),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_in              (i_in),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_out             (o_out)
    );

    // ------------------------------------------------------------------------
    // Shadow of the blitter: glyph store, column tracking, pen and registers
    // ------------------------------------------------------------------------
    logic [15:0] glyph_rows [GLYPH_COUNT*MAX_GLYPH_HEIGHT];
    logic [3:0]  right_column [GLYPH_COUNT];
    logic [3:0]  digit_column;
    logic [15:0] string_width;
    logic [15:0] pen_x;
    logic [11:0] pen_y;

    logic [12:0] stride;
    logic [4:0]  cell_width;
    logic [5:0]  cell_height;
    logic [7:0]  spacing;
    logic        align_right;

    t_out_item   expected_writes [$];
    int unsigned error_count = 0;

    // Stimulus bookkeeping
    t_in_item    pending_items [$];
    int unsigned items_queued   = 0;
    int unsigned items_accepted = 0;
    int unsigned phase_items    = 0;
    logic [31:0] rows_loaded [GLYPH_COUNT];   // each glyph row goes in once
    logic [7:0]  used_codes [$];

    // Idling and the long output hold-off
    int unsigned sender_idle_pct   = 0;
    int unsigned receiver_idle_pct = 0;
    int unsigned burst_requests    = 0;
    int unsigned burst_length      = 0;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic int unsigned lit_mask();
        int unsigned w;
        w = cell_width;
        if (w > MAX_GLYPH_WIDTH) w = MAX_GLYPH_WIDTH;
        if (w > 16) w = 16;
        return (32'd1 << w) - 1;
    endfunction

    // Space borrows the underscore column as is; digits share one width.
    function automatic int unsigned advance_width(logic [7:0] code);
        if (code == CH_SPACE) return right_column[CH_UNDERSCORE];
        if (code >= CH_DIGIT_LO && code <= CH_DIGIT_HI) return digit_column + 1;
        if (int'(code) >= GLYPH_COUNT) return 1;
        return right_column[code] + 1;
    endfunction

    task automatic predict_transaction(t_in_item it);
        int unsigned     rows;
        int unsigned     col;
        int unsigned     lit;
        int unsigned     sum;
        int              idx;
        longint unsigned addr;
        t_out_item       w;
        case (it.command)
            CMD_LOAD: begin
                if (int'(it.char_code) < GLYPH_COUNT && int'(it.glyph_row) < MAX_GLYPH_HEIGHT) begin
                    idx = int'(it.char_code) * MAX_GLYPH_HEIGHT + int'(it.glyph_row);
                    glyph_rows[idx] = it.row_bits;
                    lit = it.row_bits & lit_mask();
                    col = 0;
                    for (int c = 0; c < 16; c++) begin
                        if ((lit >> c) & 1) col = c;
                    end
                    if (col > right_column[it.char_code]) right_column[it.char_code] = 4'(col);
                    if (it.char_code >= CH_DIGIT_LO && it.char_code <= CH_DIGIT_HI &&
                        col > digit_column) digit_column = 4'(col);
                end
            end
            CMD_MEASURE: begin
                if (it.first_of_string) string_width = '0;
                sum = string_width + advance_width(it.char_code) + spacing;
                string_width = (sum > 32'hFFFF) ? 16'hFFFF : 16'(sum);
            end
            CMD_DRAW: begin
                rows = cell_height;
                if (rows > MAX_GLYPH_HEIGHT) rows = MAX_GLYPH_HEIGHT;
                if (rows > 32) rows = 32;
                if (it.first_of_string) begin
                    pen_y = it.pos_y;
                    if (align_right)
                        pen_x = (it.pos_x > string_width) ? it.pos_x - string_width : 16'd0;
                    else
                        pen_x = it.pos_x;
                end
                for (int unsigned j = 0; j < rows; j++) begin
                    addr = 64'(stride) * (64'(pen_y) + 64'(j)) + 64'(pen_x);
                    addr = addr & ((64'd1 << ADDRESS_BITS) - 1);
                    w.write_address = addr[23:0];
                    w.write_mask = '0;
                    if (int'(it.char_code) < GLYPH_COUNT) begin
                        idx = int'(it.char_code) * MAX_GLYPH_HEIGHT + int'(j);
                        w.write_mask = glyph_rows[idx] & 16'(lit_mask());
                    end
                    w.write_color = it.color;
                    w.last_row = (j + 1 == rows);
                    expected_writes.push_back(w);
                end
                pen_x = 16'(pen_x + advance_width(it.char_code) + spacing);
            end
            default: ;   // unused command code: no effect
        endcase
    endtask

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        if (error_count < MAX_PRINTED)
            $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // Input driver: present queued transactions, hold each until accepted
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_inputs
        logic     next_valid;
        t_in_item next_item;
        next_valid = i_in_valid;
        next_item  = i_in;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else begin
            // Predict on acceptance, so expectations exist long before results.
            if (i_in_valid && !o_in_stall) begin
                predict_transaction(i_in);
                items_accepted++;
                next_valid = 1'b0;
            end
            // Offer the next transaction unless the sender idles this cycle.
            if (!next_valid && pending_items.size() != 0 &&
                $urandom_range(0, 99) >= sender_idle_pct) begin
                next_valid = 1'b1;
                next_item  = pending_items.pop_front();
            end
        end
        i_in_valid <= next_valid;
        i_in       <= next_item;
    end

    // ------------------------------------------------------------------------
    // Output monitor: check each accepted row write, then pick the next stall
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_outputs
        t_out_item   want;
        logic        next_stall;
        int unsigned burst_left;
        int unsigned bursts_started;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_writes.size() == 0) begin
                report_mismatch("row write with nothing pending, address",
                                o_out.write_address, 0);
            end else begin
                want = expected_writes.pop_front();
                if (o_out.write_address !== want.write_address)
                    report_mismatch("write_address", o_out.write_address, want.write_address);
                if (o_out.write_mask !== want.write_mask)
                    report_mismatch("write_mask", o_out.write_mask, want.write_mask);
                if (o_out.write_color !== want.write_color)
                    report_mismatch("write_color", o_out.write_color, want.write_color);
                if (o_out.last_row !== want.last_row)
                    report_mismatch("last_row", o_out.last_row, want.last_row);
            end
        end
        // Hold off for a long stretch on request, otherwise stall at random.
        if (burst_left != 0) begin
            next_stall = 1'b1;
            burst_left--;
        end else if (burst_requests != bursts_started) begin
            bursts_started = burst_requests;
            burst_left     = burst_length;
            next_stall     = 1'b1;
        end else begin
            next_stall = ($urandom_range(0, 99) < receiver_idle_pct);
        end
        i_out_stall <= next_stall;
    end

    // ------------------------------------------------------------------------
    // Configuration and stimulus helpers
    // ------------------------------------------------------------------------
    task automatic write_register(t_cfg_index idx, int unsigned value);
        @(posedge i_clk);
        i_cfg_write_enable <= 1'b1;
        i_cfg_index        <= idx;
        i_cfg_data         <= 13'(value);
        case (idx)
            CFG_SCREEN_STRIDE: stride      = 13'(value);
            CFG_GLYPH_WIDTH:   cell_width  = 5'(value);
            CFG_GLYPH_HEIGHT:  cell_height = 6'(value);
            CFG_CHAR_SPACING:  spacing     = 8'(value);
            CFG_ALIGN_RIGHT:   align_right = 1'(value);
            default: ;
        endcase
    endtask

    // Only called with the block idle.
    task automatic configure(int unsigned s, int unsigned w, int unsigned h,
                             int unsigned sp, int unsigned al);
        write_register(CFG_SCREEN_STRIDE, s);
        write_register(CFG_GLYPH_WIDTH, w);
        write_register(CFG_GLYPH_HEIGHT, h);
        write_register(CFG_CHAR_SPACING, sp);
        write_register(CFG_ALIGN_RIGHT, al);
        @(posedge i_clk);
        i_cfg_write_enable <= 1'b0;
    endtask

    task automatic set_idling(int unsigned sender_pct, int unsigned receiver_pct);
        sender_idle_pct   = sender_pct;
        receiver_idle_pct = receiver_pct;
    endtask

    // Wait for every transaction and row write, then let the block settle.
    task automatic wait_idle();
        while (items_accepted != items_queued || expected_writes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_in_item random_item(t_command cmd, logic [7:0] code);
        t_in_item it;
        it.command         = cmd;
        it.char_code       = code;
        it.glyph_row       = 5'($urandom);
        it.row_bits        = 16'($urandom);
        it.first_of_string = 1'($urandom);
        it.pos_x           = 16'($urandom);
        it.pos_y           = 12'($urandom);
        it.color           = 8'($urandom);
        return it;
    endfunction

    task automatic push_item(t_in_item it);
        pending_items.push_back(it);
        items_queued++;
        phase_items++;
    endtask

    task automatic queue_text(t_command cmd, logic [7:0] code, logic first,
                              logic [15:0] x, logic [11:0] y, logic [7:0] color);
        t_in_item it;
        it = random_item(cmd, code);
        it.first_of_string = first;
        it.pos_x = x;
        it.pos_y = y;
        it.color = color;
        push_item(it);
    endtask

    task automatic queue_load(logic [7:0] code, logic [4:0] row, logic [15:0] bits);
        t_in_item it;
        it = random_item(CMD_LOAD, code);
        it.glyph_row = row;
        it.row_bits  = bits;
        rows_loaded[code][row] = 1'b1;
        push_item(it);
    endtask

    // Narrow masks half of the time so the rightmost column varies.
    function automatic logic [15:0] random_row_bits();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1, 2, 3: return 16'($urandom);
            default: return 16'($urandom) & 16'((32'd1 << $urandom_range(1, 16)) - 1);
        endcase
    endfunction

    // Load whatever rows of the glyph a draw at the current height reads.
    task automatic prepare_glyph(logic [7:0] code);
        int unsigned rows;
        rows = cell_height;
        if (rows > MAX_GLYPH_HEIGHT) rows = MAX_GLYPH_HEIGHT;
        if (rows > 32) rows = 32;
        for (int unsigned r = 0; r < rows; r++) begin
            if (!rows_loaded[code][r]) queue_load(code, 5'(r), random_row_bits());
        end
        used_codes.push_back(code);
    endtask

    function automatic logic [7:0] pick_code();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 20) return CH_SPACE;
        if (r < 35) return 8'(CH_DIGIT_LO + $urandom_range(0, 9));
        if (r < 45) return CH_UNDERSCORE;
        if (r < 85 && used_codes.size() != 0)
            return used_codes[$urandom_range(0, used_codes.size() - 1)];
        return 8'($urandom);
    endfunction

    // Well-formed string: loads first, an optional measure pass, then the draws.
    task automatic queue_string();
        logic [7:0]  codes [$];
        logic        measured;
        logic [15:0] x;
        logic [11:0] y;
        logic [7:0]  color;
        repeat ($urandom_range(1, 6)) codes.push_back(pick_code());
        foreach (codes[i]) prepare_glyph(codes[i]);
        measured = align_right ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 3) == 0);
        if (measured) begin
            foreach (codes[i])
                queue_text(CMD_MEASURE, codes[i], i == 0, 16'($urandom), 12'($urandom),
                           8'($urandom));
        end
        x     = 16'($urandom);
        y     = 12'($urandom);
        color = 8'($urandom);
        foreach (codes[i]) queue_text(CMD_DRAW, codes[i], i == 0, x, y, color);
    endtask

    task automatic queue_spare_load();
        logic [7:0] code;
        logic [4:0] row;
        repeat (8) begin
            code = 8'($urandom);
            row  = 5'($urandom);
            if (!rows_loaded[code][row]) begin
                queue_load(code, row, random_row_bits());
                break;
            end
        end
    endtask

    // Mostly strings; the rest loose loads, measures, dead commands and
    // draws that continue or restart a string out of turn.
    task automatic queue_traffic(int unsigned count);
        int unsigned r;
        logic [7:0]  code;
        phase_items = 0;
        while (phase_items < count) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                queue_string();
            end else if (r < 72) begin
                queue_spare_load();
            end else if (r < 84) begin
                push_item(random_item(CMD_MEASURE, 8'($urandom)));
            end else if (r < 90) begin
                push_item(random_item(CMD_NONE, 8'($urandom)));
            end else begin
                code = pick_code();
                prepare_glyph(code);
                push_item(random_item(CMD_DRAW, code));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : clock_gen
        forever #(PERIOD_NS / 2) i_clk = ~i_clk;
    end

    initial begin : run_limit
        #(PERIOD_NS * LIMIT_CYCLES);
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        foreach (glyph_rows[i]) glyph_rows[i] = '0;
        foreach (right_column[i]) right_column[i] = '0;
        foreach (rows_loaded[i]) rows_loaded[i] = '0;
        digit_column = '0;
        string_width = '0;
        pen_x        = '0;
        pen_y        = '0;
        stride       = 13'd640;
        cell_width   = 5'd8;
        cell_height  = 6'd8;
        spacing      = '0;
        align_right  = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_idling(24, 49);

        // Directed: two-row glyphs, full-width tracking, extremes of the fields.
        configure(640, 16, 2, 0, 0);
        queue_load(CH_UNDERSCORE, 0, 16'hFFFF);      // rightmost column 15
        queue_load(CH_UNDERSCORE, 1, 16'h0001);
        queue_load(CH_SPACE, 0, 16'h1234);
        queue_load(CH_SPACE, 1, 16'h0000);
        queue_load(CH_DIGIT_LO, 0, 16'h0007);
        queue_load(CH_DIGIT_LO, 1, 16'h0000);
        queue_load(CH_DIGIT_HI, 0, 16'h0100);        // widest digit sets all
        queue_load(CH_DIGIT_HI, 1, 16'h0001);
        queue_load(8'hFF, 0, 16'hFFFF);
        queue_load(8'hFF, 1, 16'hAAAA);
        queue_load(8'h00, 0, 16'h0000);              // blank glyph, width 1
        queue_load(8'h00, 1, 16'h0000);
        queue_text(CMD_MEASURE, CH_UNDERSCORE, 1'b1, 16'hFFFF, 12'hFFF, 8'hFF);
        queue_text(CMD_MEASURE, CH_SPACE, 1'b0, 16'h0000, 12'h000, 8'h00);
        queue_text(CMD_MEASURE, 8'h35, 1'b0, 16'h0000, 12'h000, 8'h00);
        queue_text(CMD_MEASURE, 8'h00, 1'b0, 16'h0000, 12'h000, 8'h00);
        push_item(random_item(CMD_NONE, 8'hFF));
        // Pen at the far corner: its column wraps on the first advance.
        queue_text(CMD_DRAW, CH_UNDERSCORE, 1'b1, 16'hFFFF, 12'hFFF, 8'hFF);
        queue_text(CMD_DRAW, CH_DIGIT_LO, 1'b0, 16'h0000, 12'h000, 8'h00);
        queue_text(CMD_DRAW, 8'hFF, 1'b0, 16'h0000, 12'h000, 8'h5A);
        queue_text(CMD_DRAW, CH_SPACE, 1'b1, 16'h0000, 12'h000, 8'hA5);
        wait_idle();

        // Directed: right alignment, clamped at zero and not.
        configure(640, 16, 2, 255, 1);
        queue_text(CMD_MEASURE, CH_DIGIT_HI, 1'b1, 16'h0000, 12'h000, 8'h00);
        queue_text(CMD_DRAW, CH_DIGIT_HI, 1'b1, 16'd100, 12'd7, 8'h11);
        queue_text(CMD_DRAW, CH_DIGIT_LO, 1'b1, 16'hFFFF, 12'd9, 8'h22);
        wait_idle();

        configure(640, 8, 8, 1, 0);
        queue_traffic(15);
        wait_idle();

        configure(4096, 16, 1, 255, 1);
        queue_traffic(10);
        wait_idle();

        // Sender side idles more from here on.
        set_idling(49, 24);

        // Tall glyphs: hold the output off long enough to back up the input.
        configure(1, 1, 32, 0, 0);
        queue_traffic(10);
        burst_length = 3000;
        burst_requests++;
        wait_idle();

        // Zero stride, zero width, zero height: no row writes, pen still moves.
        configure(0, 0, 0, 3, 1);
        queue_traffic(8);
        wait_idle();

        // Drive the string total into saturation, then align against it.
        // The underscore advances 16 columns, so each measure adds 271.
        configure(100, 16, 4, 255, 1);
        prepare_glyph(CH_UNDERSCORE);
        queue_text(CMD_MEASURE, CH_UNDERSCORE, 1'b1, 16'($urandom), 12'($urandom), 8'($urandom));
        repeat (243)
            queue_text(CMD_MEASURE, CH_UNDERSCORE, 1'b0, 16'($urandom), 12'($urandom),
                       8'($urandom));
        queue_text(CMD_DRAW, CH_UNDERSCORE, 1'b1, 16'($urandom), 12'($urandom), 8'($urandom));
        queue_text(CMD_DRAW, CH_UNDERSCORE, 1'b0, 16'($urandom), 12'($urandom), 8'($urandom));
        queue_text(CMD_DRAW, CH_UNDERSCORE, 1'b1, 16'hFFFF, 12'($urandom), 8'($urandom));
        wait_idle();

        // No idling on either side.
        set_idling(0, 0);

        // Out-of-range width and height clamp to 16 columns and 32 rows.
        configure(8191, 31, 63, 17, 1);
        queue_traffic(10);
        wait_idle();

        configure(320, 12, 5, 2, 0);
        queue_traffic(12);
        wait_idle();

        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
